// ----- sv/usv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usv_pkg: shared types and constants of the UV sphere vertex generator
// Queue entry and result layouts, trig constants, vertex ordering tables.
// ----------------------------------------------------------------------------
package usv_pkg;

    localparam int IDX_BITS_DEF = 8;
    localparam int FIELD_W      = 8;
    localparam int POS_W        = 16;
    localparam int MAG_W        = 31;
    localparam int PROD_W       = 2 * MAG_W;
    localparam int DEN_W        = 10;
    localparam int DIV_W        = 40;
    localparam int DIV_PER_CYC  = 4;
    localparam int DIV_CYC      = DIV_W / DIV_PER_CYC;
    localparam int CMD_DEPTH    = 2;
    localparam int RES_DEPTH    = 2;
    localparam int CFG_IDX_W    = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLICE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUT   = 1'b1;

    localparam logic [FIELD_W-1:0] SLICE_RST = 8'd8;
    localparam logic [FIELD_W-1:0] CUT_RST   = 8'd16;
    localparam logic [FIELD_W-1:0] MIN_CUT   = 8'd3;

    localparam logic [MAG_W-1:0] ONE_Q30   = 31'h4000_0000;
    localparam logic [16:0]      ONE_Q14   = 17'd16384;

    // ring and edge choice of each vertex in the run, bit k for vertex k
    localparam logic [5:0] RING_SEL  = 6'b010110;
    localparam logic [5:0] EDGE_SEL  = 6'b110100;
    localparam logic [2:0] LAST_CAP  = 3'd2;
    localparam logic [2:0] LAST_BODY = 3'd5;

    typedef struct packed {
        logic               bad;
        logic               cap;
        logic [FIELD_W-1:0] ring0;
        logic [FIELD_W-1:0] seg;
    } cmd_t;

    typedef struct packed {
        logic [FIELD_W-1:0] n;
        logic [DEN_W-1:0]   d;
    } trig_req_t;

    typedef struct packed {
        logic [MAG_W-1:0] sin_mag;
        logic             sin_neg;
        logic [MAG_W-1:0] cos_mag;
        logic             cos_neg;
    } trig_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [2:0]              vertex_slot;
        logic                    bad_request;
        logic                    last_vertex;
    } res_t;

    // Q30 Taylor coefficients of sin(pi/2 * u)
    function automatic logic [MAG_W-1:0] coef(input logic [2:0] idx);
        logic [MAG_W-1:0] c;
        case (idx)
            3'd0:    c = 31'd1686629713;
            3'd1:    c = 31'd693598668;
            3'd2:    c = 31'd85569306;
            3'd3:    c = 31'd5026995;
            3'd4:    c = 31'd172272;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [FIELD_W-1:0] idx_mask(input int bits);
        return FIELD_W'((1 << bits) - 1);
    endfunction

    // saturate a Q14 magnitude and apply the sign, zero stays positive
    function automatic logic [POS_W-1:0] q14_field(input logic [16:0] mag, input logic neg);
        logic [POS_W-1:0] sat;
        sat = (mag > ONE_Q14) ? POS_W'(ONE_Q14) : mag[POS_W-1:0];
        return (neg && (sat != '0)) ? POS_W'(~sat + 16'd1) : sat;
    endfunction

endpackage

// ----- sv/usv_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usv_fifo: small register queue
// Push/full on the write side, pop/empty on the read side, head shown at rdata.
// ----------------------------------------------------------------------------
module usv_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // store the incoming beat
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- sv/usv_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usv_front: request intake
// Masks and range-checks each request and queues it for the vertex engine.
// ----------------------------------------------------------------------------
module usv_front import usv_pkg::*; #(
    parameter int INDEX_BITS = IDX_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [FIELD_W-1:0] band_index,
    input  logic [FIELD_W-1:0] segment_index,
    input  logic [FIELD_W-1:0] slice_count,
    input  logic [FIELD_W-1:0] cut_count,
    output logic               cmd_empty,
    input  logic               cmd_pop,
    output cmd_t               cmd_data
);

    localparam logic [FIELD_W-1:0] IDX_MASK = idx_mask(INDEX_BITS);

    logic [FIELD_W-1:0] band;
    logic [FIELD_W-1:0] seg;
    cmd_t               cmd_in;
    logic [$bits(cmd_t)-1:0] cmd_bits;

    // classify the request
    always_comb
    begin
        band         = band_index & IDX_MASK;
        seg          = segment_index & IDX_MASK;
        cmd_in.bad   = (cut_count < MIN_CUT) || (band >= slice_count) || (seg >= cut_count);
        cmd_in.cap   = (band == '0);
        cmd_in.ring0 = band;
        cmd_in.seg   = seg;
    end

    usv_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_bits),
        .empty (cmd_empty)
    );

    assign cmd_data = cmd_t'(cmd_bits);

endmodule

// ----- sv/usv_trig.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usv_trig: sine and cosine of a fraction of a turn
// Radix-16 divider for the quarter position, then two interleaved Horner
// polynomials on one shared 31x31 multiplier.
// ----------------------------------------------------------------------------
module usv_trig import usv_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  trig_req_t req,
    output logic      done,
    output trig_t     res
);

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_DIV  = 2'd1;
    localparam logic [1:0] T_POLY = 2'd2;
    localparam int         STEPS  = 12;

    logic [1:0]        state_reg, state_next;
    logic [3:0]        div_cnt_reg, div_cnt_next;
    logic [3:0]        step_reg, step_next;
    logic              mul_v_reg, mul_v_next;
    logic              done_reg, done_next;
    logic [DIV_W-1:0]  num_reg, num_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic [1:0]        quad_reg;
    logic [MAG_W-1:0]  x_reg  [2];
    logic [MAG_W-1:0]  x2_reg [2];
    logic [MAG_W-1:0]  p_reg  [2];
    logic              mul_j_reg;
    logic [2:0]        mul_s_reg;
    logic [PROD_W-1:0] prod_reg;

    logic              j;
    logic [2:0]        s;
    logic [MAG_W-1:0]  mul_a;
    logic [MAG_W-1:0]  mul_b;
    logic [PROD_W-1:0] product;
    logic [MAG_W-1:0]  sh;
    logic [MAG_W-1:0]  u_ext;

    // four quotient bits a cycle
    always_comb
    begin
        logic [DEN_W:0] rem2;
        logic           qb;
        num_next = num_reg;
        rem_next = rem_reg;
        for (int i = 0; i < DIV_PER_CYC; i++)
        begin
            rem2 = {rem_next, num_next[DIV_W-1]};
            if (rem2 >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(rem2 - {1'b0, den_reg});
                qb       = 1'b1;
            end
            else
            begin
                rem_next = rem2[DEN_W-1:0];
                qb       = 1'b0;
            end
            num_next = {num_next[DIV_W-2:0], qb};
        end
    end

    assign u_ext = {1'b0, num_next[29:0]};

    // pick multiplier operands for the current Horner step
    always_comb
    begin
        j = step_reg[0];
        s = step_reg[3:1];
        case (s)
            3'd0:
            begin
                mul_a = x_reg[j];
                mul_b = x_reg[j];
            end
            3'd1:
            begin
                mul_a = coef(3'd4);
                mul_b = x2_reg[j];
            end
            3'd5:
            begin
                mul_a = p_reg[j];
                mul_b = x_reg[j];
            end
            default:
            begin
                mul_a = p_reg[j];
                mul_b = x2_reg[j];
            end
        endcase
        product = mul_a * mul_b;
        sh      = prod_reg[60:30];
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        step_next    = step_reg;
        mul_v_next   = 1'b0;
        done_next    = 1'b0;
        case (state_reg)
            T_IDLE:
            begin
                if (start)
                begin
                    state_next   = T_DIV;
                    div_cnt_next = '0;
                end
            end
            T_DIV:
            begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == 4'(DIV_CYC - 1))
                begin
                    state_next = T_POLY;
                    step_next  = '0;
                end
            end
            T_POLY:
            begin
                if (step_reg != 4'(STEPS))
                begin
                    mul_v_next = 1'b1;
                    step_next  = step_reg + 1'b1;
                end
                else if (mul_v_reg)
                begin
                    state_next = T_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= T_IDLE;
            div_cnt_reg <= '0;
            step_reg    <= '0;
            mul_v_reg   <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
            step_reg    <= step_next;
            mul_v_reg   <= mul_v_next;
            done_reg    <= done_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == T_IDLE && start)
        begin
            num_reg <= {req.n, 2'b00, 30'(req.d >> 1)};
            rem_reg <= '0;
            den_reg <= req.d;
        end
        if (state_reg == T_DIV)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
            if (div_cnt_reg == 4'(DIV_CYC - 1))
            begin
                quad_reg  <= num_next[31:30];
                x_reg[0]  <= u_ext;
                x_reg[1]  <= ONE_Q30 - u_ext;
            end
        end
        if (state_reg == T_POLY && step_reg != 4'(STEPS))
        begin
            prod_reg  <= product;
            mul_j_reg <= j;
            mul_s_reg <= s;
        end
        // retire the previous product
        if (mul_v_reg)
        begin
            case (mul_s_reg)
                3'd0:    x2_reg[mul_j_reg] <= sh;
                3'd5:    p_reg[mul_j_reg]  <= sh;
                default: p_reg[mul_j_reg]  <= coef(3'd4 - mul_s_reg) - sh;
            endcase
        end
    end

    assign done        = done_reg;
    assign res.sin_mag = quad_reg[0] ? p_reg[1] : p_reg[0];
    assign res.cos_mag = quad_reg[0] ? p_reg[0] : p_reg[1];
    assign res.sin_neg = quad_reg[1];
    assign res.cos_neg = quad_reg[1] ^ quad_reg[0];

endmodule

// ----- sv/usv_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usv_back: vertex engine
// Takes queued requests, evaluates the ring and edge angles, forms the vertex
// positions and writes them into the result queue, or one flagged bad result.
// ----------------------------------------------------------------------------
module usv_back import usv_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [FIELD_W-1:0] slice_count,
    input  logic [FIELD_W-1:0] cut_count,
    input  logic               cmd_empty,
    output logic               cmd_pop,
    input  cmd_t               cmd_data,
    output logic               trig_start,
    output trig_req_t          trig_req,
    input  logic               trig_done,
    input  trig_t              trig_res,
    input  logic               out_full,
    output logic               out_push,
    output res_t               out_data
);

    localparam logic [2:0] B_IDLE   = 3'd0;
    localparam logic [2:0] B_BAD    = 3'd1;
    localparam logic [2:0] B_TSTART = 3'd2;
    localparam logic [2:0] B_TWAIT  = 3'd3;
    localparam logic [2:0] B_VX     = 3'd4;
    localparam logic [2:0] B_VZ     = 3'd5;
    localparam logic [2:0] B_VW     = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        ang_reg, ang_next;
    logic [2:0]        vk_reg, vk_next;
    cmd_t              cmd_reg;
    trig_t             ring_res_reg [2];
    trig_t             edge_res_reg [2];
    logic [PROD_W-1:0] prod_reg;
    logic [POS_W-1:0]  px_reg;

    logic [FIELD_W-1:0] ring1;
    logic [FIELD_W-1:0] seg1;
    logic [FIELD_W-1:0] edge1;
    logic [DEN_W-1:0]   lat_d;
    trig_t              rr;
    trig_t              er;
    logic [MAG_W-1:0]   mul_b;
    logic [PROD_W-1:0]  product;
    logic [PROD_W:0]    rsum;
    logic [16:0]        rmag;
    logic [31:0]        ysum;
    logic               last;

    // angle of the current evaluation
    always_comb
    begin
        ring1 = cmd_reg.ring0 + 1'b1;
        seg1  = cmd_reg.seg + 1'b1;
        edge1 = (seg1 == cut_count) ? '0 : seg1;
        lat_d = {9'(slice_count) + 9'd1, 1'b0};
        case (ang_reg)
            2'd0:
            begin
                trig_req.n = cmd_reg.ring0;
                trig_req.d = lat_d;
            end
            2'd1:
            begin
                trig_req.n = ring1;
                trig_req.d = lat_d;
            end
            2'd2:
            begin
                trig_req.n = cmd_reg.seg;
                trig_req.d = DEN_W'(cut_count);
            end
            default:
            begin
                trig_req.n = edge1;
                trig_req.d = DEN_W'(cut_count);
            end
        endcase
    end

    // vertex arithmetic
    always_comb
    begin
        rr      = ring_res_reg[RING_SEL[vk_reg]];
        er      = edge_res_reg[EDGE_SEL[vk_reg]];
        mul_b   = (state_reg == B_VX) ? er.sin_mag : er.cos_mag;
        product = rr.sin_mag * mul_b;
        rsum    = {1'b0, prod_reg} + (63'd1 << 45);
        rmag    = rsum[62:46];
        ysum    = {1'b0, rr.cos_mag} + 32'h0000_8000;
        last    = cmd_reg.cap ? (vk_reg == LAST_CAP) : (vk_reg == LAST_BODY);
        if (state_reg == B_BAD)
        begin
            out_data.pos_x       = '0;
            out_data.pos_y       = '0;
            out_data.pos_z       = '0;
            out_data.vertex_slot = '0;
            out_data.bad_request = 1'b1;
            out_data.last_vertex = 1'b1;
        end
        else
        begin
            out_data.pos_x       = px_reg;
            out_data.pos_y       = q14_field({1'b0, ysum[31:16]}, rr.cos_neg);
            out_data.pos_z       = q14_field(rmag, rr.sin_neg ^ er.cos_neg);
            out_data.vertex_slot = vk_reg;
            out_data.bad_request = 1'b0;
            out_data.last_vertex = last;
        end
    end

    assign cmd_pop    = (state_reg == B_IDLE) && !cmd_empty;
    assign trig_start = (state_reg == B_TSTART);
    assign out_push   = ((state_reg == B_BAD) || (state_reg == B_VW)) && !out_full;

    // request sequencer
    always_comb
    begin
        state_next = state_reg;
        ang_next   = ang_reg;
        vk_next    = vk_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    state_next = cmd_data.bad ? B_BAD : B_TSTART;
                    ang_next   = '0;
                end
            end
            B_BAD:
            begin
                if (!out_full)
                begin
                    state_next = B_IDLE;
                end
            end
            B_TSTART:
            begin
                state_next = B_TWAIT;
            end
            B_TWAIT:
            begin
                if (trig_done)
                begin
                    if (ang_reg == 2'd3)
                    begin
                        state_next = B_VX;
                        vk_next    = '0;
                    end
                    else
                    begin
                        state_next = B_TSTART;
                        ang_next   = ang_reg + 1'b1;
                    end
                end
            end
            B_VX:
            begin
                state_next = B_VZ;
            end
            B_VZ:
            begin
                state_next = B_VW;
            end
            B_VW:
            begin
                if (!out_full)
                begin
                    if (last)
                    begin
                        state_next = B_IDLE;
                    end
                    else
                    begin
                        state_next = B_VX;
                        vk_next    = vk_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            ang_reg   <= '0;
            vk_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ang_reg   <= ang_next;
            vk_reg    <= vk_next;
        end
    end

    // hold request, angle results and partial vertex
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd_data;
        end
        if (state_reg == B_TWAIT && trig_done)
        begin
            if (ang_reg[1])
            begin
                edge_res_reg[ang_reg[0]] <= trig_res;
            end
            else
            begin
                ring_res_reg[ang_reg[0]] <= trig_res;
            end
        end
        if (state_reg == B_VX || state_reg == B_VZ)
        begin
            prod_reg <= product;
        end
        if (state_reg == B_VZ)
        begin
            px_reg <= q14_field(rmag, rr.sin_neg ^ er.sin_neg);
        end
    end

    a_pop_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (state_reg == B_BAD) || (state_reg == B_TSTART))
        else $error("request taken without starting work");

    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        trig_done |-> (state_reg == B_TWAIT))
        else $error("trig result arrived while not waiting");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_push && out_data.last_vertex |=> (state_reg == B_IDLE))
        else $error("run continued past its last vertex");

    a_cap_slots: assert property (@(posedge clk) disable iff (!rst_n)
        out_push && cmd_reg.cap && !out_data.bad_request |-> (vk_reg <= LAST_CAP))
        else $error("top cap produced more than three vertices");

endmodule

// ----- sv/uv_sphere_vertex_generator.sv -----
`timescale 1ns / 1ps
// An out-of-range request gives one flagged result, pushed once the result queue has room.
// A valid request evaluates four angles in turn in the shared trig unit (start, the divider
// at 4 quotient bits, the Horner polynomial steps, done), then forms each vertex in the
// B_VX, B_VZ and B_VW states, holding in B_VW while the result queue is full; one request
// at a time. Two requests queue ahead of the engine, two results wait for pop.
// Reset: slice_count 8, cut_count 16, both queues empty; no clearing pass.
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator: UV sphere patch vertex generator
// Queue-style request and result ports, register write channel, front/back
// split with a request queue between them.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator import usv_pkg::*; #(
    parameter int INDEX_BITS = IDX_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [FIELD_W-1:0]   band_index,
    input  logic [FIELD_W-1:0]   segment_index,
    output logic                 empty,
    input  logic                 pop,
    output logic signed [15:0]   pos_x,
    output logic signed [15:0]   pos_y,
    output logic signed [15:0]   pos_z,
    output logic [2:0]           vertex_slot,
    output logic                 bad_request,
    output logic                 last_vertex,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FIELD_W-1:0]   cfg_data
);

    localparam logic [FIELD_W-1:0] IDX_MASK = idx_mask(INDEX_BITS);

    logic [FIELD_W-1:0] slice_count_reg;
    logic [FIELD_W-1:0] cut_count_reg;
    logic               cmd_empty;
    logic               cmd_pop;
    cmd_t               cmd_data;
    logic               trig_start;
    trig_req_t          trig_req;
    logic               trig_done;
    trig_t              trig_res;
    logic               out_full;
    logic               out_push;
    res_t               out_data;
    logic [$bits(res_t)-1:0] res_bits;
    res_t               res_head;

    // register writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_count_reg <= SLICE_RST;
            cut_count_reg   <= CUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SLICE: slice_count_reg <= cfg_data & IDX_MASK;
                CFG_CUT:   cut_count_reg   <= cfg_data & IDX_MASK;
                default:   ;
            endcase
        end
    end

    usv_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .band_index    (band_index),
        .segment_index (segment_index),
        .slice_count   (slice_count_reg),
        .cut_count     (cut_count_reg),
        .cmd_empty     (cmd_empty),
        .cmd_pop       (cmd_pop),
        .cmd_data      (cmd_data)
    );

    usv_trig u_trig (
        .clk   (clk),
        .rst_n (rst_n),
        .start (trig_start),
        .req   (trig_req),
        .done  (trig_done),
        .res   (trig_res)
    );

    usv_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .slice_count (slice_count_reg),
        .cut_count   (cut_count_reg),
        .cmd_empty   (cmd_empty),
        .cmd_pop     (cmd_pop),
        .cmd_data    (cmd_data),
        .trig_start  (trig_start),
        .trig_req    (trig_req),
        .trig_done   (trig_done),
        .trig_res    (trig_res),
        .out_full    (out_full),
        .out_push    (out_push),
        .out_data    (out_data)
    );

    // result queue
    usv_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (out_data),
        .full  (out_full),
        .pop   (pop),
        .rdata (res_bits),
        .empty (empty)
    );

    assign res_head    = res_t'(res_bits);
    assign pos_x       = res_head.pos_x;
    assign pos_y       = res_head.pos_y;
    assign pos_z       = res_head.pos_z;
    assign vertex_slot = res_head.vertex_slot;
    assign bad_request = res_head.bad_request;
    assign last_vertex = res_head.last_vertex;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the UV sphere vertex generator
// Drives patch requests through several slice/cut settings, predicts every
// vertex with the same integer polynomial trig and checks each popped result in order.
// ----------------------------------------------------------------------------
module testbench;
    import usv_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE_CYCLS = 150;
    localparam longint unsigned Q30_ONE = 64'd1 << 30;

    // ------------------------------------------------------------------------
    // Expected-vertex store and exact patch predictor
    // ------------------------------------------------------------------------
    class vertex_scoreboard;
        res_t vertex_q[$];
        int   mismatches;
        int   slices;
        int   cuts;

        function new();
            mismatches = 0;
            slices     = 8;
            cuts       = 16;
        endfunction

        // sine of a quarter-turn position u (Q30), odd polynomial to u^9
        function longint unsigned quarter_sin(longint unsigned u);
            longint unsigned u2;
            longint unsigned p;
            u2 = (u * u) >> 30;
            p  = 64'd172272;
            p  = 64'd5026995 - ((p * u2) >> 30);
            p  = 64'd85569306 - ((p * u2) >> 30);
            p  = 64'd693598668 - ((p * u2) >> 30);
            p  = 64'd1686629713 - ((p * u2) >> 30);
            return (p * u) >> 30;
        endfunction

        // sine of n/d turns advanced by a number of quarter turns
        function void turn_sin(input longint unsigned n, input longint unsigned d,
                               input longint unsigned quarters,
                               output longint unsigned mag, output bit neg);
            longint unsigned m;
            longint unsigned q;
            longint unsigned r;
            longint unsigned u;
            m = (n % d) * 4;
            q = (m / d + quarters) & 3;
            r = m % d;
            u = ((r << 30) + d / 2) / d;
            if (q[0])
                u = Q30_ONE - u;
            mag = quarter_sin(u);
            neg = (q >= 2) && (mag != 0);
        endfunction

        function logic [15:0] q14_pos(longint unsigned mag, bit neg);
            logic [15:0] sat;
            sat = (mag > 16384) ? 16'd16384 : mag[15:0];
            return neg ? 16'(-sat) : sat;
        endfunction

        function void add_vertex(int ring, int edge_idx, int slot, bit last);
            longint unsigned lat_d;
            longint unsigned rad, hgt, sl, cl, mx, my, mz;
            bit rad_n, hgt_n, sl_n, cl_n;
            res_t v;
            lat_d = 2 * (slices + 1);
            turn_sin(ring, lat_d, 0, rad, rad_n);
            turn_sin(ring, lat_d, 1, hgt, hgt_n);
            turn_sin(edge_idx, cuts, 0, sl, sl_n);
            turn_sin(edge_idx, cuts, 1, cl, cl_n);
            mx = (rad * sl + (64'd1 << 45)) >> 46;
            mz = (rad * cl + (64'd1 << 45)) >> 46;
            my = (hgt + (64'd1 << 15)) >> 16;
            v.pos_x       = q14_pos(mx, mx != 0 && (rad_n != sl_n));
            v.pos_y       = q14_pos(my, my != 0 && hgt_n);
            v.pos_z       = q14_pos(mz, mz != 0 && (rad_n != cl_n));
            v.vertex_slot = 3'(slot);
            v.bad_request = 1'b0;
            v.last_vertex = last;
            vertex_q.push_back(v);
        endfunction

        // note an accepted request: queue the vertices of its patch
        function void note_request(logic [7:0] band, logic [7:0] seg);
            int ring_ofs[6];
            int edge_ofs[6];
            int cnt;
            res_t v;
            ring_ofs = '{0, 1, 1, 0, 1, 0};
            edge_ofs = '{0, 0, 1, 0, 1, 1};
            if (cuts < 3 || band >= slices || seg >= cuts)
            begin
                v = '0;
                v.bad_request = 1'b1;
                v.last_vertex = 1'b1;
                vertex_q.push_back(v);
            end
            else if (band == 0)
            begin
                add_vertex(0, seg, 0, 1'b0);
                add_vertex(1, seg, 1, 1'b0);
                add_vertex(1, seg + 1, 2, 1'b1);
            end
            else
            begin
                cnt = 6;
                for (int k = 0; k < cnt; k++)
                    add_vertex(band + ring_ofs[k], seg + edge_ofs[k], k, k == cnt - 1);
            end
        endfunction

        // compare a popped vertex with the oldest expectation
        function void check_vertex(res_t got);
            res_t want;
            if (vertex_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected vertex: x=%0d y=%0d z=%0d slot=%0d bad=%0b last=%0b",
                             got.pos_x, got.pos_y, got.pos_z, got.vertex_slot,
                             got.bad_request, got.last_vertex);
                return;
            end
            want = vertex_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("vertex mismatch: exp x=%0d y=%0d z=%0d slot=%0d bad=%0b last=%0b",
                             want.pos_x, want.pos_y, want.pos_z, want.vertex_slot,
                             want.bad_request, want.last_vertex);
                    $display("                 got x=%0d y=%0d z=%0d slot=%0d bad=%0b last=%0b",
                             got.pos_x, got.pos_y, got.pos_z, got.vertex_slot,
                             got.bad_request, got.last_vertex);
                end
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [FIELD_W-1:0]   band_index = '0;
    logic [FIELD_W-1:0]   segment_index = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic signed [15:0]   pos_x;
    logic signed [15:0]   pos_y;
    logic signed [15:0]   pos_z;
    logic [2:0]           vertex_slot;
    logic                 bad_request;
    logic                 last_vertex;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SLICE;
    logic [FIELD_W-1:0]   cfg_data = '0;

    vertex_scoreboard sb = new();
    bit  quiet = 1'b0;
    int  pop_hold = 0;
    int  cycle_cnt = 0;

    uv_sphere_vertex_generator u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .band_index    (band_index),
        .segment_index (segment_index),
        .empty         (empty),
        .pop           (pop),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .vertex_slot   (vertex_slot),
        .bad_request   (bad_request),
        .last_vertex   (last_vertex),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // pop side: check each accepted beat, stall in random bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                sb.check_vertex('{pos_x, pos_y, pos_z, vertex_slot, bad_request,
                                  last_vertex});
            if (pop_hold > 0)
            begin
                pop_hold = pop_hold - 1;
                pop <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                pop_hold = $urandom_range(1, 5) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // push one request beat, with an optional idle burst ahead of it
    task automatic send_request(logic [7:0] band, logic [7:0] seg);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        push          <= 1'b1;
        band_index    <= band;
        segment_index <= seg;
        do @(posedge clk); while (full);
        sb.note_request(band, seg);
    endtask

    // hold off until every expected vertex is out and the engine is quiet
    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (sb.vertex_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLS) @(posedge clk);
    endtask

    // write one register, then idle the channel and record the new setting
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 8'(value);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_SLICE)
            sb.slices = value;
        else
            sb.cuts = value;
    endtask

    task automatic random_requests(int count);
        logic [7:0] band, seg;
        for (int i = 0; i < count; i++)
        begin
            if (sb.slices > 0 && sb.cuts > 0 && $urandom_range(0, 9) < 8)
            begin
                band = 8'($urandom_range(0, sb.slices - 1));
                seg  = 8'($urandom_range(0, sb.cuts - 1));
            end
            else
            begin
                band = 8'($urandom_range(0, 254));
                seg  = 8'($urandom_range(0, 254));
            end
            send_request(band, seg);
        end
    endtask

    initial
    begin
        int slice_set[7];
        int cut_set[7];
        int item_set[7];
        slice_set = '{1, 255, 0, 5, 4, 255, 6};
        cut_set   = '{3, 255, 7, 2, 5, 3, 12};
        item_set  = '{35, 80, 15, 15, 60, 45, 61};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset setting, caps, edges, out-of-range requests
        send_request(8'd0, 8'd0);
        send_request(8'd0, 8'd15);
        send_request(8'd1, 8'd0);
        send_request(8'd7, 8'd15);
        send_request(8'd4, 8'd8);
        send_request(8'd8, 8'd0);
        send_request(8'd0, 8'd16);
        send_request(8'd254, 8'd254);
        send_request(8'd255, 8'd255);
        drain();

        // directed: extremes of both registers
        write_reg(CFG_SLICE, 255);
        write_reg(CFG_CUT, 255);
        send_request(8'd0, 8'd254);
        send_request(8'd254, 8'd254);
        send_request(8'd254, 8'd0);
        send_request(8'd127, 8'd128);
        send_request(8'd255, 8'd0);
        send_request(8'd0, 8'd255);
        drain();
        write_reg(CFG_SLICE, 1);
        write_reg(CFG_CUT, 3);
        send_request(8'd0, 8'd0);
        send_request(8'd0, 8'd2);
        send_request(8'd1, 8'd0);
        send_request(8'd0, 8'd3);

        // random phases over several settings, the last one without idling
        for (int ph = 0; ph < 7; ph++)
        begin
            drain();
            write_reg(CFG_SLICE, slice_set[ph]);
            write_reg(CFG_CUT, cut_set[ph]);
            if (ph == 6)
                quiet = 1'b1;
            random_requests(item_set[ph]);
        end

        drain();
        if (sb.mismatches == 0 && sb.vertex_q.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
